// File: sv/rmed_pkg.sv
// Shared widths and types for the multichannel running median filter.
package rmed_pkg;

	localparam int CHAN_W   = 4;
	localparam int SAMPLE_W = 16;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [CHAN_W-1:0]          chan_t;

endpackage

// File: sv/rmed_if.sv
// Valid/ready stream interfaces for tagged samples in and medians out.
interface rmed_in_if;
	logic              valid;
	logic              ready;
	rmed_pkg::chan_t   chan;
	rmed_pkg::sample_t sample;

	modport source(output valid, output chan, output sample, input ready);
	modport sink(input valid, input chan, input sample, output ready);
endinterface

interface rmed_out_if;
	logic              valid;
	logic              ready;
	rmed_pkg::sample_t median;

	modport source(output valid, output median, input ready);
	modport sink(input valid, input median, output ready);
endinterface

// File: sv/rmed_window.sv
// Per-channel window store with fill count and oldest slot, updated once per transfer.
module rmed_window #(
	parameter int WINDOW   = 9,
	parameter int CHANNELS = 9,
	parameter int CH_IW    = 4,
	parameter int CW       = 4
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  wr_en,
	input  logic [CH_IW-1:0]                      ch,
	input  rmed_pkg::sample_t                     sample,
	output rmed_pkg::sample_t [WINDOW-1:0]        nxt_win,
	output logic [CW-1:0]                         nxt_cnt
);
	import rmed_pkg::*;

	localparam int PW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

	sample_t [WINDOW-1:0] win_q [CHANNELS];
	logic [CW-1:0]        cnt_q [CHANNELS];
	logic [PW-1:0]        pos_q [CHANNELS];

	sample_t [WINDOW-1:0] row;
	logic [CW-1:0]        cnt;
	logic [PW-1:0]        pos;
	logic [PW-1:0]        slot;
	logic [PW-1:0]        nxt_pos;
	logic                 filling;

	always_comb begin
		row     = win_q[ch];
		cnt     = cnt_q[ch];
		pos     = pos_q[ch];
		filling = (cnt < CW'(WINDOW));
		slot    = filling ? PW'(cnt) : pos;
		for (int k = 0; k < WINDOW; k++) begin
			nxt_win[k] = (PW'(k) == slot) ? sample : row[k];
		end
		if (filling) begin
			nxt_cnt = cnt + CW'(1);
			nxt_pos = pos;
		end else begin
			nxt_cnt = cnt;
			nxt_pos = (pos == PW'(WINDOW - 1)) ? '0 : pos + PW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				cnt_q[c] <= '0;
				pos_q[c] <= '0;
			end
		end else if (wr_en) begin
			cnt_q[ch] <= nxt_cnt;
			pos_q[ch] <= nxt_pos;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			win_q[ch] <= nxt_win;
		end
	end

endmodule

// File: sv/rmed_rank.sv
// Rank selection of the middle element of one window snapshot, with result register.
module rmed_rank #(
	parameter int WINDOW = 9,
	parameter int CW     = 4
) (
	input  logic                           clk,
	input  logic                           load,
	input  rmed_pkg::sample_t [WINDOW-1:0] win,
	input  logic [CW-1:0]                  cnt,
	output rmed_pkg::sample_t              median
);
	import rmed_pkg::*;

	localparam int MID = WINDOW / 2;

	logic [CW-1:0] lt_c;
	logic [CW-1:0] le_c;
	sample_t       pick;
	sample_t       med_q;

	always_comb begin
		pick = '0;
		lt_c = '0;
		le_c = '0;
		for (int i = 0; i < WINDOW; i++) begin
			lt_c = '0;
			le_c = '0;
			for (int j = 0; j < WINDOW; j++) begin
				if (CW'(j) < cnt) begin
					if (win[j] < win[i]) begin
						lt_c = lt_c + CW'(1);
					end
					if (win[j] <= win[i]) begin
						le_c = le_c + CW'(1);
					end
				end
			end
			if ((CW'(i) < cnt) && (lt_c <= CW'(MID)) && (le_c > CW'(MID))) begin
				pick = win[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			med_q <= pick;
		end
	end

	assign median = med_q;

endmodule

// File: sv/multichannel_running_median9.sv
// Top level of the multichannel running median filter with per-channel windows.
// Each result passes through the input register, the snapshot stage and the result register.
// Throughput: one sample per cycle, sustained while the median output is ready, for any mix of channels.
// The window state is updated when a sample leaves the input register, so a
// following sample of the same channel sees it at once.
// Reset clears every fill count, oldest slot and all pipeline valid flags.
module multichannel_running_median9 #(
	parameter int WINDOW   = 9,
	parameter int CHANNELS = 9
) (
	input  logic       clk,
	input  logic       arst_n,
	rmed_in_if.sink    samples,
	rmed_out_if.source medians
);
	import rmed_pkg::*;

	localparam int CH_IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CW    = $clog2(WINDOW + 1);

	localparam logic [CHAN_W:0] CH_LIM = (CHAN_W + 1)'(CHANNELS);

	logic                 s1_v_q;
	logic                 s2_v_q;
	logic                 out_v_q;
	logic [CH_IW-1:0]     ch_s1;
	sample_t              smp_s1;
	sample_t [WINDOW-1:0] win_s2;
	logic [CW-1:0]        cnt_s2;
	sample_t [WINDOW-1:0] nxt_win;
	logic [CW-1:0]        nxt_cnt;
	logic [CH_IW-1:0]     ch_in;
	logic                 out_free;
	logic                 s2_free;
	logic                 s2_adv;
	logic                 s1_adv;
	logic                 in_xfer;

	assign out_free      = !out_v_q || medians.ready;
	assign s2_adv        = s2_v_q && out_free;
	assign s2_free       = !s2_v_q || out_free;
	assign s1_adv        = s1_v_q && s2_free;
	assign samples.ready = !s1_v_q || s2_free;
	assign in_xfer       = samples.valid && samples.ready;

	assign ch_in = ({1'b0, samples.chan} >= CH_LIM) ? CH_IW'(CHANNELS - 1)
	                                                : CH_IW'(samples.chan);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			s2_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				s1_v_q <= 1'b1;
			end else if (s1_adv) begin
				s1_v_q <= 1'b0;
			end
			if (s1_adv) begin
				s2_v_q <= 1'b1;
			end else if (s2_adv) begin
				s2_v_q <= 1'b0;
			end
			if (s2_adv) begin
				out_v_q <= 1'b1;
			end else if (medians.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			ch_s1  <= ch_in;
			smp_s1 <= samples.sample;
		end
		if (s1_adv) begin
			win_s2 <= nxt_win;
			cnt_s2 <= nxt_cnt;
		end
	end

	rmed_window #(
		.WINDOW   (WINDOW),
		.CHANNELS (CHANNELS),
		.CH_IW    (CH_IW),
		.CW       (CW)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (s1_adv),
		.ch      (ch_s1),
		.sample  (smp_s1),
		.nxt_win (nxt_win),
		.nxt_cnt (nxt_cnt)
	);

	rmed_rank #(
		.WINDOW (WINDOW),
		.CW     (CW)
	) u_rank (
		.clk    (clk),
		.load   (s2_adv),
		.win    (win_s2),
		.cnt    (cnt_s2),
		.median (medians.median)
	);

	assign medians.valid = out_v_q;

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_v_q |-> samples.ready)
		else $error("Input not ready while the input register is empty.");

	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> s2_v_q)
		else $error("Sample left the input register but the snapshot stage is empty.");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_v_q && !out_free) |=> (s2_v_q && $stable(cnt_s2)))
		else $error("Snapshot stage changed while the result register was stalled.");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		s2_v_q |-> ((cnt_s2 != '0) && (cnt_s2 <= CW'(WINDOW))))
		else $error("Window fill count out of range.");

endmodule

// File: verif/tb_multichannel_running_median9.sv
// Self-checking testbench for the multichannel running median filter with per-channel windows.
module tb_multichannel_running_median9;
	import rmed_pkg::*;

	localparam int CHANNELS    = 9;
	localparam int WINDOW      = 9;
	localparam int MID         = WINDOW / 2;
	localparam int MAX_GAP     = 40;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_REPORTS = 10;

	logic clk;
	logic arst_n;

	rmed_in_if  samples_if();
	rmed_out_if medians_if();

	multichannel_running_median9 #(
		.WINDOW(WINDOW),
		.CHANNELS(CHANNELS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples_if),
		.medians(medians_if)
	);

	sample_t     window_samples [CHANNELS][WINDOW];
	int unsigned oldest_slot [CHANNELS];
	int unsigned held_count [CHANNELS];
	sample_t     expected_medians [$];
	int          src_idle_pct;
	int          sink_stall_pct;
	int          failures;
	int          cycle_count = 0;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic sample_t rank_value(input int unsigned c);
		int unsigned below;
		int unsigned not_above;
		for (int i = 0; i < held_count[c]; i++) begin
			below = 0;
			not_above = 0;
			for (int j = 0; j < held_count[c]; j++) begin
				if (window_samples[c][j] < window_samples[c][i])
					below++;
				if (window_samples[c][j] <= window_samples[c][i])
					not_above++;
			end
			if (below <= MID && MID < not_above)
				return window_samples[c][i];
		end
		return '0;
	endfunction

	function automatic sample_t predict_median(input chan_t ch, input sample_t s);
		int unsigned c;
		c = (ch >= CHANNELS) ? CHANNELS - 1 : ch;
		if (held_count[c] < WINDOW) begin
			window_samples[c][held_count[c]] = s;
			held_count[c]++;
		end else begin
			window_samples[c][oldest_slot[c]] = s;
			oldest_slot[c] = (oldest_slot[c] + 1) % WINDOW;
		end
		if (held_count[c] <= MID)
			return '0;
		return rank_value(c);
	endfunction

	function automatic chan_t pick_channel();
		if ($urandom_range(9) == 0)
			return chan_t'($urandom_range(15, CHANNELS));
		return chan_t'($urandom_range(CHANNELS - 1));
	endfunction

	function automatic sample_t pick_sample();
		case ($urandom_range(9))
			0: begin
				return sample_t'(32767);
			end
			1: begin
				return sample_t'(-32768);
			end
			2, 3: begin
				return sample_t'(int'($urandom_range(8)) - 4);
			end
			default: begin
				return sample_t'($urandom_range(65535));
			end
		endcase
	endfunction

	task automatic report_failure(input string msg);
		failures++;
		if (failures <= MAX_REPORTS)
			$display("mismatch at cycle %0d: %s", cycle_count, msg);
	endtask

	task automatic send_sample(input chan_t ch, input sample_t s);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < src_idle_pct)
			gap++;
		@(negedge clk);
		repeat (gap) begin
			samples_if.valid <= 1'b0;
			@(negedge clk);
		end
		samples_if.valid  <= 1'b1;
		samples_if.chan   <= ch;
		samples_if.sample <= s;
		do @(posedge clk); while (samples_if.ready !== 1'b1);
		expected_medians.push_back(predict_median(ch, s));
	endtask

	task automatic drain_medians();
		@(negedge clk);
		samples_if.valid <= 1'b0;
		while (expected_medians.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_fill_and_extremes();
		sample_t seq [10];
		seq = '{32767, -32768, 0, -1, 1, 100, 100, 100, -32768, -5};
		foreach (seq[i])
			send_sample(chan_t'(0), seq[i]);
		for (int i = 0; i < 4; i++)
			send_sample(chan_t'(3), sample_t'(i * 1000 - 1500));
	endtask

	task automatic test_channel_saturation();
		send_sample(chan_t'(CHANNELS - 1), sample_t'(7));
		for (int c = CHANNELS; c < 16; c++)
			send_sample(chan_t'(c), (c % 3 == 1) ? sample_t'(-7) : sample_t'(7));
		send_sample(chan_t'(15), sample_t'(-32768));
	endtask

	task automatic test_random_idle_phases();
		int src_pct [4];
		int sink_pct [4];
		src_pct  = '{0, 76, 0, 13};
		sink_pct = '{0, 0, 76, 13};
		for (int p = 0; p < 4; p++) begin
			src_idle_pct   = src_pct[p];
			sink_stall_pct = sink_pct[p];
			repeat (440)
				send_sample(pick_channel(), pick_sample());
		end
	endtask

	task automatic test_drain_pause();
		src_idle_pct   = 0;
		sink_stall_pct = 76;
		repeat (3) begin
			repeat (20)
				send_sample(pick_channel(), pick_sample());
			drain_medians();
		end
		sink_stall_pct = 0;
	endtask

	always @(negedge clk)
		medians_if.ready <= ($urandom_range(99) >= sink_stall_pct);

	always @(posedge clk) begin : check_medians
		sample_t want;
		if (arst_n && medians_if.valid === 1'b1 && medians_if.ready) begin
			if (expected_medians.size() == 0) begin
				report_failure($sformatf("median %0d with no sample pending",
					medians_if.median));
			end else begin
				want = expected_medians.pop_front();
				if (medians_if.median !== want)
					report_failure($sformatf("expected median %0d, got %0d",
						want, medians_if.median));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		arst_n            = 1'b0;
		samples_if.valid  = 1'b0;
		samples_if.chan   = '0;
		samples_if.sample = '0;
		medians_if.ready  = 1'b0;
		src_idle_pct      = 0;
		sink_stall_pct    = 0;
		failures          = 0;
		for (int c = 0; c < CHANNELS; c++) begin
			oldest_slot[c] = 0;
			held_count[c]  = 0;
			for (int k = 0; k < WINDOW; k++)
				window_samples[c][k] = '0;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_fill_and_extremes();
		test_channel_saturation();
		test_random_idle_phases();
		test_drain_pause();

		drain_medians();
		repeat (8) @(posedge clk);
		if (failures == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: multichannel_running_median9.f
sv/rmed_pkg.sv
sv/rmed_if.sv
sv/rmed_window.sv
sv/rmed_rank.sv
sv/multichannel_running_median9.sv
verif/tb_multichannel_running_median9.sv
